FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files of the prime test block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property is checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: src/wtd_pkg.sv
// Package of the wheel trial-division prime test: widths, state type,
// handshake status struct and the candidate step table. No dependencies.
`default_nettype none

package wtd_pkg;

    // Magnitude bits of the tested number; the request field has a sign bit on top.
    localparam int NUM_BITS  = 53;
    localparam int IN_W      = NUM_BITS + 1;
    // Floor square root width and the even-width radicand it is taken from.
    localparam int ROOT_W    = (NUM_BITS + 1) / 2;
    localparam int SQ_W      = 2 * ROOT_W;
    // A candidate can pass the root by at most one wheel step, hence one bit more.
    localparam int CAND_W    = ROOT_W + 1;
    localparam int SQ_CNT_W  = $clog2(ROOT_W + 1);
    localparam int DV_CNT_W  = $clog2(NUM_BITS + 1);

    // Divisor sequence: 3 and 5 first, then the eight wheel slots, repeating.
    localparam int SLOT_W = 4;
    localparam logic [SLOT_W-1:0] SLOT_THREE       = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_FIRST_WHEEL = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_LAST        = 4'd9;
    localparam logic [CAND_W-1:0] CAND_FIRST       = CAND_W'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_TRY,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_sts;

    // Distance from the candidate of a slot to the next candidate.
    function automatic logic [2:0] f_cand_step(input logic [SLOT_W-1:0] slot);
        logic [2:0] step;
        case (slot)
            4'd0:    step = 3'd2; // 3 -> 5
            4'd1:    step = 3'd2; // 5 -> 7
            4'd2:    step = 3'd4; // 7 -> 11
            4'd3:    step = 3'd2; // 11 -> 13
            4'd4:    step = 3'd4; // 13 -> 17
            4'd5:    step = 3'd2; // 17 -> 19
            4'd6:    step = 3'd4; // 19 -> 23
            4'd7:    step = 3'd6; // 23 -> 29
            4'd8:    step = 3'd2; // 29 -> 31
            4'd9:    step = 3'd6; // 31 -> 37 of the next turn
            default: step = 3'd2;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

FILE: src/wtd_if.sv
// Request and response channel interfaces of the prime test block.
// Depends on wtd_pkg for the field widths.
`default_nettype none

interface wtd_in_if import wtd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface wtd_out_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

FILE: src/wtd_sqrt.sv
// Bit-serial exact floor square root, one root bit per cycle.
// Depends on wtd_pkg.
`default_nettype none

module wtd_sqrt import wtd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    output t_seq_sts                 o_sts,
    output logic      [ROOT_W-1:0]   o_root
);

    logic [SQ_W-1:0]     r_sh;
    logic [ROOT_W:0]     r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_done;

    logic [ROOT_W+2:0] w_part;
    logic [ROOT_W+2:0] w_trial;
    logic              w_fit;

    // Bring down the next two radicand bits and try the root bit as one.
    assign w_part  = {r_rem, r_sh[SQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_fit   = (w_part >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == SQ_CNT_W'(1));
            if (i_start) begin
                r_cnt <= SQ_CNT_W'(ROOT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - SQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh   <= SQ_W'(i_num);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_sh <= {r_sh[SQ_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= (ROOT_W+1)'(w_part - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_part[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_root     = r_root;

endmodule

`default_nettype wire

FILE: src/wtd_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle, MSB first.
// Depends on wtd_pkg.
`default_nettype none

module wtd_rem import wtd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [CAND_W-1:0]   i_div,
    output t_seq_sts                 o_sts,
    output logic                     o_zero
);

    logic [NUM_BITS-1:0] r_sh;
    logic [CAND_W-1:0]   r_rem;
    logic [CAND_W-1:0]   r_div;
    logic [DV_CNT_W-1:0] r_cnt;
    logic                r_done;

    logic [CAND_W:0] w_part;
    logic [CAND_W:0] w_div;

    assign w_part = {r_rem, r_sh[NUM_BITS-1]};
    assign w_div  = {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DV_CNT_W'(1));
            if (i_start) begin
                r_cnt <= DV_CNT_W'(NUM_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_num;
            r_rem <= '0;
            r_div <= i_div;
        end else if (r_cnt != '0) begin
            r_sh <= {r_sh[NUM_BITS-2:0], 1'b0};
            if (w_part >= w_div) begin
                r_rem <= CAND_W'(w_part - w_div);
            end else begin
                r_rem <= w_part[CAND_W-1:0];
            end
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_zero     = (r_rem == '0);

endmodule

`default_nettype wire

FILE: src/wheel_trial_division_prime_test_top.sv
// Wheel-30 trial-division prime test. A request carries one signed number; the
// block answers with one response whose is_prime bit is 1 when the number is
// prime. Negative values, zero and one are not prime; 2, 3 and 5 are prime and
// other even numbers are not; these cases are settled on acceptance. Any other
// value first has its exact floor square root taken bit-serially (ROOT_W = 27
// steps), and is then divided by 3, 5 and the wheel candidates 30i + 7, 11,
// 13, 17, 19, 23, 29, 31 in turn, up to that root. Each trial division goes
// through a restoring remainder unit that consumes one dividend bit per cycle.
// The first candidate that divides the number ends the search with a not-prime
// answer. One number is worked on at a time. The answer sits in an output
// register, so a new request is taken as soon as the search has handed its
// result over, even while the previous response still waits to be taken.
// Depends on wtd_pkg, wtd_if, wtd_sqrt, wtd_rem and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wheel_trial_division_prime_test_top import wtd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wtd_in_if.sink    i_req,
    wtd_out_if.source o_rsp
);

    t_state r_state;
    t_state n_state;

    // The magnitude of the number under test and the search position.
    logic [NUM_BITS-1:0] r_num;
    logic [CAND_W-1:0]   r_cand;
    logic [CAND_W-1:0]   n_cand;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic                r_res;
    logic                n_res;

    // Output register.
    logic r_out_valid;
    logic r_out_prime;

    logic                w_accept;
    logic [NUM_BITS-1:0] w_mag;
    logic                w_neg;
    logic                w_quick;
    logic                w_quick_res;
    logic                w_past_root;
    logic                w_out_free;
    logic                w_sqrt_start;
    logic                w_rem_start;

    t_seq_sts          w_sqrt_sts;
    t_seq_sts          w_rem_sts;
    logic [ROOT_W-1:0] w_root;
    logic              w_rem_zero;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_mag    = i_req.number[NUM_BITS-1:0];
    assign w_neg    = i_req.number[NUM_BITS];

    // Cases answered without any division: negatives, values below two,
    // the small primes two, three and five, and every other even value.
    always_comb begin
        w_quick     = 1'b1;
        w_quick_res = 1'b0;
        if (w_neg || (w_mag[NUM_BITS-1:1] == '0)) begin
            w_quick_res = 1'b0;
        end else if ((w_mag == NUM_BITS'(2)) || (w_mag == NUM_BITS'(3))
                     || (w_mag == NUM_BITS'(5))) begin
            w_quick_res = 1'b1;
        end else if (!w_mag[0]) begin
            w_quick_res = 1'b0;
        end else begin
            w_quick = 1'b0;
        end
    end

    // The divisors 3 and 5 are always tried; wheel candidates stop at the root.
    assign w_past_root = (r_slot >= SLOT_FIRST_WHEEL) && (r_cand > {1'b0, w_root});

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_quick ? S_DONE : S_ROOT;
                end
            end
            S_ROOT: begin
                if (w_sqrt_sts.done) begin
                    n_state = S_TRY;
                end
            end
            S_TRY: begin
                n_state = w_past_root ? S_DONE : S_WAIT;
            end
            S_WAIT: begin
                if (w_rem_sts.done) begin
                    n_state = w_rem_zero ? S_DONE : S_TRY;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Unit starts and the next search position and verdict.
    always_comb begin
        w_sqrt_start = 1'b0;
        w_rem_start  = 1'b0;
        n_cand       = r_cand;
        n_slot       = r_slot;
        n_res        = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_sqrt_start = !w_quick;
                    n_res        = w_quick_res;
                    n_cand       = CAND_FIRST;
                    n_slot       = SLOT_THREE;
                end
            end
            S_TRY: begin
                if (w_past_root) begin
                    n_res = 1'b1;
                end else begin
                    w_rem_start = 1'b1;
                end
            end
            S_WAIT: begin
                if (w_rem_sts.done) begin
                    if (w_rem_zero) begin
                        n_res = 1'b0;
                    end else begin
                        n_cand = r_cand + CAND_W'(f_cand_step(r_slot));
                        n_slot = (r_slot == SLOT_LAST) ? SLOT_FIRST_WHEEL
                                                       : r_slot + SLOT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_num <= w_mag;
        end
        r_cand <= n_cand;
        r_slot <= n_slot;
        r_res  <= n_res;
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_prime <= r_res;
        end
    end

    wtd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_num   (w_mag),
        .o_sts   (w_sqrt_sts),
        .o_root  (w_root)
    );

    wtd_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_num   (r_num),
        .i_div   (r_cand),
        .o_sts   (w_rem_sts),
        .o_zero  (w_rem_zero)
    );

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.is_prime = r_out_prime;

    // A new request is only taken when neither serial unit is still working.
    `ASSERT_CLK(a_idle_units, i_req.ready |-> (!w_sqrt_sts.busy && !w_rem_sts.busy),
        "request accepted while a serial unit is busy")
    // The root finishes only while the controller waits for it.
    `ASSERT_CLK(a_sqrt_done, w_sqrt_sts.done |-> (r_state == S_ROOT),
        "square root finished outside the root phase")
    // A remainder finishes only while the controller waits for it.
    `ASSERT_CLK(a_rem_done, w_rem_sts.done |-> (r_state == S_WAIT),
        "remainder finished outside the division phase")
    // Every trial divisor is odd; an even one means the step table slipped.
    `ASSERT_NEVER(a_cand_odd, (r_state == S_TRY) && !r_cand[0],
        "even trial divisor")

endmodule

`default_nettype wire

FILE: tb/prime_verdict_checker.sv
// Checker for the wheel-30 prime test block: watches both channels, works out
// the expected verdict of every accepted request and compares each response.
// Depends on wtd_pkg and wtd_if.
`default_nettype none

module prime_verdict_checker import wtd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wtd_in_if           i_req,
    wtd_out_if          i_rsp,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    // Gaps between successive wheel candidates 7, 11, 13, 17, 19, 23, 29, 31, 37,
    // four bits per slot with the gap after 7 in the lowest nibble.
    localparam logic [31:0] WHEEL_GAPS = {4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd4, 4'd2, 4'd4};

    typedef struct {
        logic signed [IN_W-1:0] number;
        bit                     is_prime;
    } t_awaited_verdict;

    t_awaited_verdict awaited_verdicts [$];

    // Primality of the request field: the sign bit makes it not prime, otherwise the
    // magnitude is divided by 2, 3, 5 and the wheel candidates up to its floor root.
    function automatic bit expected_is_prime(input logic signed [IN_W-1:0] number);
        longint unsigned value;
        longint unsigned remainder;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned divisor;
        int unsigned     slot;
        if (number[IN_W-1]) begin
            return 1'b0;
        end
        value = '0;
        value[NUM_BITS-1:0] = number[NUM_BITS-1:0];
        if (value < 2) begin
            return 1'b0;
        end
        if (value == 2 || value == 3 || value == 5) begin
            return 1'b1;
        end
        if (value % 2 == 0 || value % 3 == 0 || value % 5 == 0) begin
            return 1'b0;
        end
        // Exact floor square root, two radicand bits per step.
        remainder = value;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > remainder) begin
            probe = probe >> 2;
        end
        while (probe != 0) begin
            if (remainder >= root + probe) begin
                remainder = remainder - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        divisor = 7;
        slot = 0;
        while (divisor <= root) begin
            if (value % divisor == 0) begin
                return 1'b0;
            end
            divisor = divisor + WHEEL_GAPS[slot*4 +: 4];
            slot = (slot + 1) % 8;
        end
        return 1'b1;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_awaited_verdict oldest;
        t_awaited_verdict incoming;
        if (i_rst_n) begin
            // The response is handled first, so that a request accepted at the same
            // edge can never be matched with it.
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_verdicts.size() == 0) begin
                    $error("is_prime: expected no response, actual %0b", i_rsp.is_prime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    oldest = awaited_verdicts.pop_front();
                    if (i_rsp.is_prime !== oldest.is_prime) begin
                        $error("is_prime for number %0d: expected %0b, actual %0b",
                               oldest.number, oldest.is_prime, i_rsp.is_prime);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                incoming.number = i_req.number;
                incoming.is_prime = expected_is_prime(i_req.number);
                awaited_verdicts.push_back(incoming);
            end
        end
        o_pending <= awaited_verdicts.size();
    end

endmodule

`default_nettype wire

FILE: tb/wheel_trial_division_prime_test_top_test.sv
// Top of the prime test bench: clock, reset, request stimulus and response pacing
// around the block, with prime_verdict_checker beside it giving the failure count.
// Depends on wtd_pkg, wtd_if, prime_verdict_checker and the block itself.
`default_nettype none

module wheel_trial_division_prime_test_top_test;
    import wtd_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_ITEMS     = 100;
    // Long enough for the block to finish two of the slowest random numbers, so that
    // it holds one in its search and one answer in its output register, and then to
    // refuse further requests for a good while.
    localparam int LONG_HOLD_CYCLES = 40000;
    // Extra time at the end that covers any straggler.
    localparam int SETTLE_CYCLES    = 200;
    // The limit leaves ample room for the slowest correct run: the largest directed
    // value tries about 1700 candidates, and the mid-sized primes and the response
    // stalls add to that.
    localparam int LIMIT_CYCLES     = 3_000_000;
    localparam longint unsigned MAX_MAGNITUDE = (64'd1 << NUM_BITS) - 64'd1;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    bit          long_hold_go = 1'b0;
    int unsigned verdict_failures;
    int unsigned verdicts_pending;
    int unsigned cycle_count;

    wtd_in_if  req_if ();
    wtd_out_if rsp_if ();

    wheel_trial_division_prime_test_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    prime_verdict_checker u_verdict_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (verdict_failures),
        .o_pending    (verdicts_pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Presents one number at the falling edge and holds it until the block takes
    // it. The request is accepted at the rising edge at which ready is seen high,
    // so the caller may present the next one straight away at the following
    // falling edge without valid ever dropping in between.
    task automatic offer_number(input logic signed [IN_W-1:0] number);
        @(negedge i_clk);
        req_if.valid  <= 1'b1;
        req_if.number <= number;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
    endtask

    // Withdraws the request and waits until every verdict owed by the block has
    // been collected by the checker.
    task automatic wait_for_all_verdicts();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (verdicts_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Request side: a directed set first, then random numbers in bursts.
    initial begin : request_stimulus
        logic signed [IN_W-1:0] directed_numbers [$];
        logic signed [IN_W-1:0] candidate;
        longint unsigned        wide;
        longint unsigned        multiple;
        int unsigned            factor;
        int unsigned            pick;
        int unsigned            burst_left;
        int unsigned            gap;
        int                     tiny;

        req_if.valid  = 1'b0;
        req_if.number = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The edges of the range and the cases settled without any search: zero,
        // one, minus one and the most negative pattern, then the small primes and
        // their first multiples. Squares of wheel candidates put the divisor
        // exactly on the floor root, and the largest magnitude is a composite
        // whose smallest factor is 6361, so it exercises a long search.
        directed_numbers = '{
            IN_W'(0), IN_W'(1), -IN_W'(1), {1'b1, {NUM_BITS{1'b0}}},
            IN_W'(2), IN_W'(3), IN_W'(5), IN_W'(4), IN_W'(6), IN_W'(9),
            IN_W'(15), IN_W'(25), IN_W'(7), IN_W'(31), IN_W'(37), IN_W'(49),
            IN_W'(121), IN_W'(961), IN_W'(1369), IN_W'(3599), IN_W'(65521),
            {1'b0, {NUM_BITS{1'b1}}}, {1'b0, {(NUM_BITS-1){1'b1}}, 1'b0},
            {1'b1, {NUM_BITS{1'b1}}}
        };
        // Sent back to back, so this part runs with no gaps on the request side.
        foreach (directed_numbers[i]) begin
            offer_number(directed_numbers[i]);
        end
        wait_for_all_verdicts();

        // The response side holds off for a long stretch as soon as the random
        // part starts, while requests keep coming.
        long_hold_go <= 1'b1;
        burst_left = $urandom_range(1, 16);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Half way through the request side pauses until the block has emptied.
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_all_verdicts();
            end
            // Values that reach a long search are kept small; large positive values
            // always carry a small factor, so the search stops early on them.
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                candidate = IN_W'($urandom_range(0, 4095));
            end else if (pick < 40) begin
                candidate = IN_W'($urandom_range(1 << 16, 1 << 20));
            end else if (pick < 70) begin
                factor = $urandom_range(2, 97);
                wide = {$urandom(), $urandom()};
                multiple = wide % (MAX_MAGNITUDE / factor) + 64'd1;
                candidate = IN_W'(multiple * factor);
            end else if (pick < 90) begin
                wide = {$urandom(), $urandom()};
                candidate = {1'b1, wide[NUM_BITS-1:0]};
            end else begin
                tiny = int'($urandom_range(0, 63)) - 3;
                candidate = IN_W'(tiny);
            end
            offer_number(candidate);

            burst_left--;
            if (burst_left == 0) begin
                // A quarter of the bursts run straight into the next one.
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                repeat (gap) begin
                    @(negedge i_clk);
                    req_if.valid  <= 1'b0;
                    req_if.number <= IN_W'({$urandom(), $urandom()});
                end
                burst_left = $urandom_range(1, 16);
            end
        end

        wait_for_all_verdicts();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (verdict_failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Response side: ready follows a pattern that is picked anew at random whenever
    // its run ends, with one long hold-off when the random part begins.
    initial begin : response_pacing
        t_rx_mode    rx_mode;
        int unsigned mode_left;
        bit          long_hold_done;

        rsp_if.ready = 1'b0;
        rx_mode = RX_ALWAYS;
        mode_left = 0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_go && !long_hold_done) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS: begin
                        rsp_if.ready <= 1'b1;
                    end
                    RX_COIN: begin
                        rsp_if.ready <= 1'($urandom_range(0, 1));
                    end
                    RX_SPARSE: begin
                        rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        // Ready and stalled in alternating runs, following bit 3 of the mode counter.
                        rsp_if.ready <= mode_left[3];
                    end
                endcase
            end
        end
    end

    // Watchdog: a run that has not finished by the limit is a failure.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: wheel_trial_division_prime_test_top.f
+incdir+src
src/wtd_pkg.sv
src/wtd_if.sv
src/wtd_sqrt.sv
src/wtd_rem.sv
src/wheel_trial_division_prime_test_top.sv
tb/prime_verdict_checker.sv
tb/wheel_trial_division_prime_test_top_test.sv
